>>> hw/rtl/bgse_pkg.sv
package bgse_pkg;

    localparam int DATA_W  = 8;   // input byte
    localparam int ACC_W   = 13;  // held bits plus one byte
    localparam int CNT_W   = 4;   // bit count of a queued word, up to 13
    localparam int LEFT_W  = 5;   // leftover bits between bytes, always below 6
    localparam int HELD_W  = 3;   // count of leftover bits
    localparam int GRP_W   = 3;   // group size register
    localparam int VAL_W   = 6;   // widest group value
    localparam int SYM_W   = 7;   // ASCII symbol
    localparam int ADDR_W  = 3;
    localparam int APB_DW  = 32;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int MAX_GROUPS = 8;

    localparam logic [GRP_W-1:0] BPS_RESET = 3'd6;

    // Register index, taken from paddr above the byte offset.
    localparam logic [ADDR_W-3:0] REG_BPS = 1'b0;

    typedef struct packed {
        logic [ACC_W-1:0] word;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } t_entry;

    // Register value to group size: zero acts as one, seven as six.
    function automatic logic [GRP_W-1:0] eff_group(input logic [GRP_W-1:0] raw);
        logic [GRP_W-1:0] n;
        n = raw;
        if (raw == 3'd0) n = 3'd1;
        if (raw == 3'd7) n = 3'd6;
        return n;
    endfunction

    function automatic logic [VAL_W-1:0] group_mask(input logic [GRP_W-1:0] n);
        logic [VAL_W:0] m;
        m = (7'd1 << n) - 7'd1;
        return m[VAL_W-1:0];
    endfunction

    // Bits consumed by the full groups found in total bits: the largest
    // multiple of n that does not exceed total.
    function automatic logic [CNT_W-1:0] bits_used(input logic [CNT_W-1:0] total,
                                                  input logic [GRP_W-1:0] n);
        logic [CNT_W-1:0] used;
        logic [6:0]       prod;
        used = '0;
        prod = '0;
        for (int k = 1; k <= MAX_GROUPS; k++) begin
            prod = 7'(k) * 7'(n);
            if (prod <= 7'(total)) used = prod[CNT_W-1:0];
        end
        return used;
    endfunction

    // Digits, lower case, upper case, underscore, dash.
    function automatic logic [SYM_W-1:0] symbol_char(input logic [VAL_W-1:0] v);
        logic [SYM_W-1:0] c;
        if (v < 6'd10)
            c = 7'(v) + 7'd48;
        else if (v < 6'd36)
            c = 7'(v) + 7'd87;
        else if (v < 6'd62)
            c = 7'(v) + 7'd29;
        else if (v == 6'd62)
            c = 7'd95;
        else
            c = 7'd45;
        return c;
    endfunction

endpackage

>>> hw/rtl/bgse_front.sv
module bgse_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic [bgse_pkg::GRP_W-1:0]   i_group,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [bgse_pkg::DATA_W-1:0]  i_data_byte,
    input  logic                         i_last_byte,
    input  logic                         i_q_ready,
    output logic                         o_push,
    output bgse_pkg::t_entry             o_entry
);
    import bgse_pkg::*;

    logic [LEFT_W-1:0] r_acc;
    logic [HELD_W-1:0] r_held;
    logic [ACC_W-1:0]  combined;
    logic [ACC_W-1:0]  shifted;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  rest;

    // The new byte lands directly above the leftover bits.
    always_comb begin
        combined = ACC_W'(r_acc) | (ACC_W'(i_data_byte) << r_held);
        total    = CNT_W'(r_held) + CNT_W'(DATA_W);
        used     = bits_used(total, i_group);
        rest     = total - used;
        shifted  = combined >> used;
    end

    assign o_in_ready    = i_q_ready;
    assign o_push        = i_in_valid && i_q_ready;
    assign o_entry.word  = combined;
    assign o_entry.cnt   = total;
    assign o_entry.last  = i_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc  <= '0;
            r_held <= '0;
        end else if (o_push) begin
            if (i_last_byte) begin
                r_acc  <= '0;
                r_held <= '0;
            end else begin
                r_acc  <= shifted[LEFT_W-1:0];
                r_held <= rest[HELD_W-1:0];
            end
        end
    end

endmodule

>>> hw/rtl/bgse_queue.sv
module bgse_queue #(
    parameter int DEPTH = bgse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bgse_pkg::t_entry i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output bgse_pkg::t_entry o_data
);
    import bgse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    t_entry            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [FILL_W-1:0] r_fill;
    logic              push_ok;
    logic              pop_ok;

    assign o_ready = (r_fill != FILL_W'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push_ok) r_wr <= wrap_inc(r_wr);
            if (pop_ok)  r_rd <= wrap_inc(r_rd);
            if (push_ok && !pop_ok)
                r_fill <= r_fill + 1'b1;
            else if (pop_ok && !push_ok)
                r_fill <= r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wr] <= i_data;
    end

endmodule

>>> hw/rtl/bgse_back.sv
module bgse_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bgse_pkg::GRP_W-1:0]  i_group,
    input  logic                        i_q_valid,
    input  bgse_pkg::t_entry            i_q_entry,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bgse_pkg::SYM_W-1:0]  o_symbol,
    output logic                        o_last_symbol
);
    import bgse_pkg::*;

    logic             r_busy;
    logic [ACC_W-1:0] r_word;
    logic [CNT_W-1:0] r_cnt;
    logic             r_last;
    logic             r_vld;
    logic [SYM_W-1:0] r_sym;
    logic             r_sym_last;

    logic             out_free;
    logic             emit;
    logic             fin;
    logic             load;
    logic [VAL_W-1:0] grp;
    logic [CNT_W-1:0] cnt_next;

    // A word is finished once nothing is left, or only a partial group is
    // left that will not be flushed.
    always_comb begin
        out_free = !r_vld || i_out_ready;
        emit     = r_busy && out_free;
        grp      = r_word[VAL_W-1:0] & group_mask(i_group);
        cnt_next = (r_cnt >= CNT_W'(i_group)) ? r_cnt - CNT_W'(i_group) : '0;
        fin      = (cnt_next == '0) || ((cnt_next < CNT_W'(i_group)) && !r_last);
        load     = i_q_valid && (!r_busy || (emit && fin));
    end

    assign o_pop         = load;
    assign o_out_valid   = r_vld;
    assign o_symbol      = r_sym;
    assign o_last_symbol = r_sym_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            if (load)
                r_busy <= 1'b1;
            else if (emit && fin)
                r_busy <= 1'b0;
            if (emit)
                r_vld <= 1'b1;
            else if (i_out_ready)
                r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_q_entry.word;
            r_cnt  <= i_q_entry.cnt;
            r_last <= i_q_entry.last;
        end else if (emit) begin
            r_word <= r_word >> i_group;
            r_cnt  <= cnt_next;
        end
        if (emit) begin
            r_sym      <= symbol_char(grp);
            r_sym_last <= r_last && fin;
        end
    end

endmodule

>>> hw/rtl/bit_group_symbol_encoder.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_data_byte, i_last_byte
// output    out        o_out_valid / i_out_ready o_symbol, o_last_symbol
// config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// The back end produces one symbol per cycle while it holds a word and the
// output is not stalled, so a byte yields floor((held + 8) / n) symbols at
// group size n, one more when a last byte leaves a partial group to pad: one
// or two symbols at six bits (up to three on a last byte), eight at one bit.
// The front end takes a byte every cycle while the queue has room.
// A byte passes the queue and the back end's word register on its way out.
// Reset is synchronous and active low; it clears the queue, both ends and
// the output register, and loads the group size with six.
// A stalled output holds its symbol; the back end and then the queue fill
// behind it, and o_in_ready drops only when the queue is full.
module bit_group_symbol_encoder #(
    parameter int QUEUE_DEPTH = bgse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Byte transfers.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bgse_pkg::DATA_W-1:0]   i_data_byte,
    input  logic                          i_last_byte,
    // Symbol transfers.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bgse_pkg::SYM_W-1:0]    o_symbol,
    output logic                          o_last_symbol,
    // Register port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bgse_pkg::ADDR_W-1:0]   paddr,
    input  logic [bgse_pkg::APB_DW-1:0]   pwdata,
    output logic [bgse_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import bgse_pkg::*;

    logic [GRP_W-1:0]  r_bps;
    logic [ADDR_W-3:0] reg_idx;
    logic              bps_write;
    logic [GRP_W-1:0]  group;

    logic              q_ready;
    logic              push;
    t_entry            push_entry;
    logic              q_valid;
    logic              pop;
    t_entry            q_entry;

    // Register file: one register, bits_per_symbol, at byte address zero.
    // Writing it also drops any partial group held by the front end.
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign bps_write = psel && penable && pwrite && (reg_idx == REG_BPS);
    assign pready    = 1'b1;
    assign prdata    = (reg_idx == REG_BPS) ? APB_DW'(r_bps) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps <= BPS_RESET;
        end else if (bps_write) begin
            r_bps <= pwdata[GRP_W-1:0];
        end
    end

    // Zero acts as one and seven as six for everything downstream.
    assign group = eff_group(r_bps);

    // Front end: merges each byte with the leftover bits and hands the whole
    // word to the queue, keeping only the partial group for the next byte.
    bgse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (bps_write),
        .i_group     (group),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    bgse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_entry)
    );

    // Back end: shifts one group per cycle, while the output is not stalled,
    // out of the current word into the output register, and flags the final symbol of a stream.
    bgse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_group       (group),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_entry),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_symbol      (o_symbol),
        .o_last_symbol (o_last_symbol)
    );

endmodule

>>> hw/rtl/bgse_checker.sv
module bgse_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [bgse_pkg::SYM_W-1:0]  o_symbol,
    input logic                        o_last_symbol,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [bgse_pkg::ADDR_W-1:0] paddr,
    input logic [bgse_pkg::APB_DW-1:0] pwdata,
    input logic [bgse_pkg::APB_DW-1:0] prdata
);
    import bgse_pkg::*;

    // No symbol is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("symbol offered after reset");

    // A stalled symbol keeps its value and flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_symbol) && $stable(o_last_symbol))
        else $error("stalled symbol changed");

    // The group size register comes out of reset as six.
    a_bps_reset: assert property (@(posedge i_clk)
        !i_rst_n ##1 (paddr[ADDR_W-1:2] == REG_BPS) |->
            prdata[GRP_W-1:0] == BPS_RESET)
        else $error("group size reset value wrong");

    // A write to the group size register reads back in the next cycle.
    a_bps_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_BPS)
            ##1 (paddr[ADDR_W-1:2] == REG_BPS) |->
            prdata[GRP_W-1:0] == $past(pwdata[GRP_W-1:0]))
        else $error("group size readback mismatch");

endmodule

bind bit_group_symbol_encoder bgse_checker u_bgse_checker (.*);
